// ===== design/azl_pkg.sv =====
// Shared types, register codes and lookup tables for the angle zone locator.
`default_nettype none

package azl_pkg;

    // Fixed field widths of the transaction payloads and registers.
    localparam int ANGLE_W    = 10;
    localparam int BOUND_W    = 10;
    localparam int ZONE_W     = 3;
    localparam int SPEED_W    = 5;
    localparam int COUNT_W    = 4;
    localparam int TOL_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 40;
    localparam int BOUNDS_LOW_W  = 4 * BOUND_W;
    localparam int BOUNDS_HIGH_W = 3 * BOUND_W;

    // Zone codes with special meaning for the lag detector.
    localparam logic [ZONE_W-1:0] ZONE_LAST         = 3'd7;
    localparam logic [ZONE_W-1:0] ZONE_NO_LAG_FIRST = 3'd6;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_ANGLE_A     = 3'd0,
        CFG_ZERO_ANGLE_B     = 3'd1,
        CFG_ZERO_ANGLE_C     = 3'd2,
        CFG_ZERO_TOLERANCE   = 3'd3,
        CFG_ZONE_BOUNDS_LOW  = 3'd4,
        CFG_ZONE_BOUNDS_HIGH = 3'd5
    } cfg_index_t;

    // Programmed register contents.
    typedef struct packed {
        logic [ANGLE_W-1:0]       zero_angle_a;
        logic [ANGLE_W-1:0]       zero_angle_b;
        logic [ANGLE_W-1:0]       zero_angle_c;
        logic [ANGLE_W-1:0]       zero_tolerance;
        logic [BOUNDS_LOW_W-1:0]  zone_bounds_low;
        logic [BOUNDS_HIGH_W-1:0] zone_bounds_high;
    } cfg_regs_t;

    // Input transaction payload.
    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic               step_level;
        logic               hold_level;
    } in_item_t;

    // Result transaction payload.
    typedef struct packed {
        logic [SPEED_W-1:0] speed_code;
        logic [ZONE_W-1:0]  zone;
        logic               lag_flag;
    } out_item_t;

    // Speed code selected by the confirmed zone.
    function automatic logic [SPEED_W-1:0] speed_for_zone(input logic [ZONE_W-1:0] zone);
        logic [SPEED_W-1:0] speed;
        case (zone)
            3'd1:    speed = 5'd9;
            3'd2:    speed = 5'd6;
            3'd3:    speed = 5'd3;
            3'd4:    speed = 5'd5;
            3'd5:    speed = 5'd4;
            default: speed = 5'd0;
        endcase
        return speed;
    endfunction

    // Allowed angle travel between step edges, by confirmed zone.
    function automatic logic [TOL_W-1:0] lag_tol_for_zone(input logic [ZONE_W-1:0] zone);
        logic [TOL_W-1:0] tol;
        case (zone)
            3'd4, 3'd5: tol = 3'd7;
            3'd7:       tol = 3'd0;
            default:    tol = 3'd4;
        endcase
        return tol;
    endfunction

endpackage

`default_nettype wire

// ===== design/azl_circ_dist.sv =====
// Circular distance between two angles on a full turn of 2^ANGLE_BITS.
`default_nettype none

module azl_circ_dist #(
    parameter int ANGLE_BITS = 10
) (
    input  wire logic [ANGLE_BITS-1:0] a,
    input  wire logic [ANGLE_BITS-1:0] b,
    output logic      [ANGLE_BITS-1:0] distance
);

    localparam int AW = ANGLE_BITS;
    localparam logic [AW-1:0] HALF = {1'b1, {(AW-1){1'b0}}};

    logic [AW-1:0] diff;

    // Absolute difference, folded back over the half turn.
    always_comb
    begin
        diff     = (a >= b) ? (a - b) : (b - a);
        distance = (diff > HALF) ? ({AW{1'b0}} - diff) : diff;
    end

endmodule

`default_nettype wire

// ===== design/azl_zone.sv =====
// Zero tracking, zone classification and zone debounce with its state.
`default_nettype none

module azl_zone
    import azl_pkg::*;
#(
    parameter int ANGLE_BITS      = 10,
    parameter int CONFIRM_SAMPLES = 10
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic [ANGLE_BITS-1:0] angle,
    input  wire cfg_regs_t             cfg,
    output logic      [ZONE_W-1:0]     zone
);

    localparam int AW    = ANGLE_BITS;
    localparam int CW    = ((AW > BOUND_W) ? AW : BOUND_W) + 2;
    localparam int THIRD = (2 ** AW) / 3;

    logic [AW-1:0] zero_a;
    logic [AW-1:0] zero_b;
    logic [AW-1:0] zero_c;
    logic [AW-1:0] dist_a;
    logic [AW-1:0] dist_b;
    logic [AW-1:0] dist_c;
    logic [AW-1:0] dist_cur;
    logic [AW-1:0] zero_sel;
    logic [AW-1:0] best_zero;
    logic [AW-1:0] best_dist;
    logic          snap;

    logic [BOUNDS_LOW_W+BOUNDS_HIGH_W-1:0] all_bounds;
    logic [1:0]            damper;
    logic signed [CW-1:0]  dist_s;
    logic signed [CW-1:0]  limit_s;
    logic [ZONE_W-1:0]     verify;
    logic [COUNT_W-1:0]    count_inc;

    logic [AW-1:0]      current_zero_reg;
    logic [AW-1:0]      current_zero_next;
    logic [ZONE_W-1:0]  candidate_zone_reg;
    logic [ZONE_W-1:0]  candidate_zone_next;
    logic [COUNT_W-1:0] confirm_count_reg;
    logic [COUNT_W-1:0] confirm_count_next;
    logic               hysteresis_on_reg;
    logic               hysteresis_on_next;
    logic [ZONE_W-1:0]  confirmed_zone_reg;
    logic [ZONE_W-1:0]  confirmed_zone_next;

    assign zero_a = AW'(cfg.zero_angle_a);
    assign zero_b = AW'(cfg.zero_angle_b);
    assign zero_c = AW'(cfg.zero_angle_c);

    // Distances from the sample to each calibrated zero.
    azl_circ_dist #(.ANGLE_BITS(AW)) u_dist_a (.a(zero_a), .b(angle), .distance(dist_a));
    azl_circ_dist #(.ANGLE_BITS(AW)) u_dist_b (.a(zero_b), .b(angle), .distance(dist_b));
    azl_circ_dist #(.ANGLE_BITS(AW)) u_dist_c (.a(zero_c), .b(angle), .distance(dist_c));

    // A zero within tolerance takes over; the last one in order wins.
    always_comb
    begin
        zero_sel = current_zero_reg;
        if (CW'(dist_a) < CW'(cfg.zero_tolerance))
        begin
            zero_sel = zero_a;
        end
        if (CW'(dist_b) < CW'(cfg.zero_tolerance))
        begin
            zero_sel = zero_b;
        end
        if (CW'(dist_c) < CW'(cfg.zero_tolerance))
        begin
            zero_sel = zero_c;
        end
    end

    azl_circ_dist #(.ANGLE_BITS(AW)) u_dist_cur (.a(zero_sel), .b(angle), .distance(dist_cur));

    // Nearest zero for the snap, ties going to the earlier zero.
    always_comb
    begin
        best_zero = zero_a;
        best_dist = dist_a;
        if (dist_b < best_dist)
        begin
            best_zero = zero_b;
            best_dist = dist_b;
        end
        if (dist_c < best_dist)
        begin
            best_zero = zero_c;
        end
        snap              = (dist_cur > AW'(THIRD));
        current_zero_next = snap ? best_zero : zero_sel;
    end

    // Zone classification: highest zone whose bound the distance exceeds.
    assign all_bounds = {cfg.zone_bounds_high, cfg.zone_bounds_low};
    assign damper     = hysteresis_on_reg ? 2'd2 : 2'd0;
    assign dist_s     = signed'(CW'(dist_cur));

    always_comb
    begin
        verify  = '0;
        limit_s = '0;
        for (int k = 1; k <= 7; k++)
        begin
            limit_s = signed'(CW'(all_bounds[BOUND_W*k-1 -: BOUND_W])) - signed'(CW'(damper));
            if (dist_s > limit_s)
            begin
                verify = ZONE_W'(k);
            end
        end
    end

    // Debounce: a zone is confirmed after enough equal samples in a row.
    assign count_inc = confirm_count_reg + 1'b1;

    always_comb
    begin
        candidate_zone_next = candidate_zone_reg;
        confirm_count_next  = confirm_count_reg;
        hysteresis_on_next  = hysteresis_on_reg;
        confirmed_zone_next = confirmed_zone_reg;
        if (verify == candidate_zone_reg)
        begin
            if (count_inc == COUNT_W'(CONFIRM_SAMPLES))
            begin
                hysteresis_on_next  = 1'b0;
                confirm_count_next  = '0;
                confirmed_zone_next = verify;
            end
            else
            begin
                confirm_count_next = count_inc;
            end
        end
        else
        begin
            if (candidate_zone_reg > verify)
            begin
                hysteresis_on_next = 1'b1;
            end
            candidate_zone_next = verify;
            confirm_count_next  = '0;
        end
    end

    assign zone = confirmed_zone_next;

    // Tracker state, updated once per transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_zero_reg   <= '0;
            candidate_zone_reg <= '0;
            confirm_count_reg  <= '0;
            hysteresis_on_reg  <= 1'b0;
            confirmed_zone_reg <= '0;
        end
        else if (en)
        begin
            current_zero_reg   <= current_zero_next;
            candidate_zone_reg <= candidate_zone_next;
            confirm_count_reg  <= confirm_count_next;
            hysteresis_on_reg  <= hysteresis_on_next;
            confirmed_zone_reg <= confirmed_zone_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/azl_lag.sv =====
// Step-edge lag detector and speed code selection with the detector state.
`default_nettype none

module azl_lag
    import azl_pkg::*;
#(
    parameter int ANGLE_BITS = 10
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  en,
    input  wire logic [ANGLE_BITS-1:0] angle,
    input  wire logic                  step_level,
    input  wire logic                  hold_level,
    input  wire logic [ZONE_W-1:0]     zone,
    output logic      [SPEED_W-1:0]    speed_code,
    output logic                       lag_flag
);

    localparam int AW = ANGLE_BITS;

    logic [TOL_W-1:0] tol;
    logic [AW-1:0]    start_dist;
    logic             run;

    logic          lag_armed_reg;
    logic          lag_armed_next;
    logic [AW-1:0] lag_start_angle_reg;
    logic [AW-1:0] lag_start_angle_next;
    logic          lag_result_reg;
    logic          lag_result_next;
    logic          expected_step_level_reg;
    logic          expected_step_level_next;

    assign tol = lag_tol_for_zone(zone);
    assign run = (zone != ZONE_LAST);

    // Travel since the step edge that armed the detector.
    azl_circ_dist #(.ANGLE_BITS(AW)) u_start_dist (
        .a        (lag_start_angle_reg),
        .b        (angle),
        .distance (start_dist)
    );

    // Hold low clears the detector; a step edge arms it or judges the travel.
    always_comb
    begin
        lag_armed_next           = lag_armed_reg;
        lag_start_angle_next     = lag_start_angle_reg;
        lag_result_next          = lag_result_reg;
        expected_step_level_next = expected_step_level_reg;
        if (!hold_level)
        begin
            lag_armed_next           = 1'b0;
            lag_start_angle_next     = angle;
            lag_result_next          = 1'b0;
            expected_step_level_next = 1'b0;
        end
        if (step_level != expected_step_level_next)
        begin
            if (lag_armed_next)
            begin
                if (start_dist > AW'(tol))
                begin
                    lag_armed_next           = 1'b0;
                    lag_result_next          = 1'b0;
                    expected_step_level_next = step_level;
                end
                else
                begin
                    lag_result_next = 1'b1;
                end
            end
            else
            begin
                lag_start_angle_next     = angle;
                expected_step_level_next = step_level;
                lag_armed_next           = 1'b1;
            end
        end
    end

    // Lag is never reported in the two top zones; lag forces speed to zero.
    assign lag_flag   = (zone < ZONE_NO_LAG_FIRST) && lag_result_next;
    assign speed_code = lag_flag ? '0 : speed_for_zone(zone);

    // Detector state, updated only when the detector runs for a transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lag_armed_reg           <= 1'b0;
            lag_start_angle_reg     <= '0;
            lag_result_reg          <= 1'b0;
            expected_step_level_reg <= 1'b0;
        end
        else if (en && run)
        begin
            lag_armed_reg           <= lag_armed_next;
            lag_start_angle_reg     <= lag_start_angle_next;
            lag_result_reg          <= lag_result_next;
            expected_step_level_reg <= expected_step_level_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/angle_zone_locator_speed_select_core.sv =====
// Top level: register file, input register, zone stage, lag stage and result register.
`default_nettype none

// Angle zone locator with speed select. Each input transaction carries a shaft
// angle and the step and hold pin levels and produces exactly one result
// transaction with the speed code, the confirmed zone and the lag flag. The
// block is a three-register pipeline: an input register, a stage register after
// the zero tracking and zone debounce logic, and the result register after the
// lag detector. A new transaction is accepted every cycle while out_ready keeps
// the pipeline from backing up; the state feedback of each stage closes within
// that stage, so the one-per-cycle rate holds. Every stage moves independently,
// so the block keeps accepting input while a result waits for out_ready until
// all three registers are full. Configuration writes are always ready and must
// be issued only while the pipeline is empty.
module angle_zone_locator_speed_select_core
    import azl_pkg::*;
#(
    parameter int ANGLE_BITS      = 10,
    parameter int CONFIRM_SAMPLES = 10
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output out_item_t                  out_data,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW = ANGLE_BITS;

    cfg_regs_t cfg_reg;

    logic     s0_valid_reg;
    in_item_t s0_item_reg;
    logic     s1_valid_reg;
    logic [AW-1:0]     s1_angle_reg;
    logic              s1_step_reg;
    logic              s1_hold_reg;
    logic [ZONE_W-1:0] s1_zone_reg;
    logic      out_valid_reg;
    out_item_t out_item_reg;

    logic out_free;
    logic s1_ready;
    logic s0_move;
    logic s1_move;
    logic in_take;

    logic [ZONE_W-1:0]  zone_calc;
    logic [SPEED_W-1:0] speed_calc;
    logic               lag_calc;

    // Configuration register file; writes beyond the list are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_ZERO_ANGLE_A:     cfg_reg.zero_angle_a     <= cfg_data[ANGLE_W-1:0];
                CFG_ZERO_ANGLE_B:     cfg_reg.zero_angle_b     <= cfg_data[ANGLE_W-1:0];
                CFG_ZERO_ANGLE_C:     cfg_reg.zero_angle_c     <= cfg_data[ANGLE_W-1:0];
                CFG_ZERO_TOLERANCE:   cfg_reg.zero_tolerance   <= cfg_data[ANGLE_W-1:0];
                CFG_ZONE_BOUNDS_LOW:  cfg_reg.zone_bounds_low  <= cfg_data[BOUNDS_LOW_W-1:0];
                CFG_ZONE_BOUNDS_HIGH: cfg_reg.zone_bounds_high <= cfg_data[BOUNDS_HIGH_W-1:0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Pipeline flow control: a stage takes a transaction when empty or draining.
    assign out_free = !out_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || out_free;
    assign in_ready = !s0_valid_reg || s1_ready;
    assign in_take  = in_valid && in_ready;
    assign s0_move  = s0_valid_reg && s1_ready;
    assign s1_move  = s1_valid_reg && out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s0_valid_reg <= in_valid;
            end
            if (s1_ready)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Zone stage.
    azl_zone #(
        .ANGLE_BITS      (AW),
        .CONFIRM_SAMPLES (CONFIRM_SAMPLES)
    ) u_zone (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (s0_move),
        .angle (AW'(s0_item_reg.angle)),
        .cfg   (cfg_reg),
        .zone  (zone_calc)
    );

    // Lag stage.
    azl_lag #(
        .ANGLE_BITS (AW)
    ) u_lag (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (s1_move),
        .angle      (s1_angle_reg),
        .step_level (s1_step_reg),
        .hold_level (s1_hold_reg),
        .zone       (s1_zone_reg),
        .speed_code (speed_calc),
        .lag_flag   (lag_calc)
    );

    // Payload registers of the three stages.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s0_item_reg <= in_data;
        end
        if (s0_move)
        begin
            s1_angle_reg <= AW'(s0_item_reg.angle);
            s1_step_reg  <= s0_item_reg.step_level;
            s1_hold_reg  <= s0_item_reg.hold_level;
            s1_zone_reg  <= zone_calc;
        end
        if (s1_move)
        begin
            out_item_reg.speed_code <= speed_calc;
            out_item_reg.zone       <= s1_zone_reg;
            out_item_reg.lag_flag   <= lag_calc;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule

`default_nettype wire

// ===== sim/tb_angle_zone_locator_speed_select_core.sv =====
// Self-checking testbench for the angle zone locator with speed select.
module tb_angle_zone_locator_speed_select_core;
    timeunit 1ns;
    timeprecision 1ps;
    import azl_pkg::*;

    localparam int FULL_TURN       = 1 << ANGLE_W;
    localparam int HALF_TURN       = FULL_TURN / 2;
    localparam int THIRD_TURN      = FULL_TURN / 3;
    localparam int CONFIRM_SAMPLES = 10;
    localparam int PIPE_LATENCY    = 3;
    localparam int PHASE_COUNT     = 9;
    localparam int PHASE_SAMPLES   = 106;
    localparam int LONG_HOLD       = 200;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int SHOWN_ERRORS    = 10;

    localparam logic [SPEED_W-1:0] SPEED_BY_ZONE [8] =
        '{5'd0, 5'd9, 5'd6, 5'd3, 5'd5, 5'd4, 5'd0, 5'd0};
    localparam int LAG_TOL_BY_ZONE [8] = '{4, 4, 4, 4, 7, 7, 4, 0};

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Samples waiting to be offered and results the block still owes.
    in_item_t  sample_queue[$];
    out_item_t zone_reports_due[$];

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int rx_hold_requests = 0;
    int rx_hold_served = 0;
    int rx_hold_left = 0;
    int bad_reports = 0;
    int cycle_count = 0;

    // Predictor copy of the registers and of the locator state.
    cfg_regs_t          regs_model = '0;
    logic [ANGLE_W-1:0] track_zero = '0;
    int                 cand_zone = 0;
    int                 confirm_cnt = 0;
    logic               hyst_on = 1'b0;
    logic [ZONE_W-1:0]  conf_zone = '0;
    logic               lag_armed = 1'b0;
    logic [ANGLE_W-1:0] lag_start = '0;
    logic               lag_hit = 1'b0;
    logic               exp_step = 1'b0;

    // Random sequence generator state.
    int   run_left = 0;
    int   run_base = 0;
    int   run_drift = 1;
    logic run_noise = 1'b0;
    logic step_now = 1'b0;

    angle_zone_locator_speed_select_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Shortest way around the circle between two angles.
    function automatic int ring_dist(input logic [ANGLE_W-1:0] x, input logic [ANGLE_W-1:0] y);
        int d;
        d = int'(x) - int'(y);
        if (d < 0)
            d = -d;
        if (d > HALF_TURN)
            d = FULL_TURN - d;
        return d;
    endfunction

    // Advances the predicted locator state by one sample and returns its result.
    function automatic out_item_t locate_zone_and_speed(input in_item_t s);
        int                 tol;
        int                 da;
        int                 db;
        int                 dc;
        int                 zero_dist;
        int                 best_d;
        int                 damper;
        int                 bound;
        int                 verdict;
        int                 k;
        logic [ANGLE_W-1:0] best;
        logic [ZONE_W-1:0]  zone;
        logic               lag;
        out_item_t          r;
        tol = int'(regs_model.zero_tolerance);
        da = ring_dist(regs_model.zero_angle_a, s.angle);
        db = ring_dist(regs_model.zero_angle_b, s.angle);
        dc = ring_dist(regs_model.zero_angle_c, s.angle);

        // Zero tracking: the last zero within tolerance wins.
        if (da < tol)
            track_zero = regs_model.zero_angle_a;
        if (db < tol)
            track_zero = regs_model.zero_angle_b;
        if (dc < tol)
            track_zero = regs_model.zero_angle_c;
        zero_dist = ring_dist(track_zero, s.angle);

        // Too far from the tracked zero: snap to the nearest, lower index on a tie.
        if (zero_dist > THIRD_TURN)
        begin
            best = regs_model.zero_angle_a;
            best_d = da;
            if (db < best_d)
            begin
                best_d = db;
                best = regs_model.zero_angle_b;
            end
            if (dc < best_d)
                best = regs_model.zero_angle_c;
            track_zero = best;
        end

        // Zone classification, highest matching bound first; no match means zone 0.
        damper = hyst_on ? 2 : 0;
        verdict = 0;
        for (k = 7; k >= 1; k--)
        begin
            if (k <= 4)
                bound = int'(regs_model.zone_bounds_low[BOUND_W*(k-1) +: BOUND_W]);
            else
                bound = int'(regs_model.zone_bounds_high[BOUND_W*(k-5) +: BOUND_W]);
            if (verdict == 0 && zero_dist > bound - damper)
                verdict = k;
        end

        // Debounce with hysteresis after a downward change.
        if (verdict == cand_zone)
        begin
            confirm_cnt = (confirm_cnt + 1) & 15;
            if (confirm_cnt == CONFIRM_SAMPLES)
            begin
                hyst_on = 1'b0;
                confirm_cnt = 0;
                conf_zone = verdict[ZONE_W-1:0];
            end
        end
        else
        begin
            if (cand_zone > verdict)
                hyst_on = 1'b1;
            cand_zone = verdict;
            confirm_cnt = 0;
        end

        // Step edge lag detector, idle in the last zone.
        zone = conf_zone;
        lag = 1'b0;
        if (zone != ZONE_LAST)
        begin
            if (!s.hold_level)
            begin
                lag_armed = 1'b0;
                lag_start = s.angle;
                lag_hit = 1'b0;
                exp_step = 1'b0;
            end
            if (s.step_level != exp_step)
            begin
                if (lag_armed)
                begin
                    if (ring_dist(lag_start, s.angle) > LAG_TOL_BY_ZONE[zone])
                    begin
                        lag_armed = 1'b0;
                        lag_hit = 1'b0;
                        exp_step = s.step_level;
                    end
                    else
                        lag_hit = 1'b1;
                end
                else
                begin
                    lag_start = s.angle;
                    exp_step = s.step_level;
                    lag_armed = 1'b1;
                end
            end
            lag = lag_hit;
        end
        if (zone >= ZONE_NO_LAG_FIRST)
            lag = 1'b0;

        r.speed_code = lag ? '0 : SPEED_BY_ZONE[zone];
        r.zone = zone;
        r.lag_flag = lag;
        return r;
    endfunction

    // Input driver: offers queued samples and predicts each accepted one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                zone_reports_due.push_back(locate_zone_and_speed(in_data));
            if (!in_valid || in_ready)
            begin
                if (sample_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data <= sample_queue.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here so the sequencer stays free.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_hold_served <= 0;
            rx_hold_left <= 0;
        end
        else if (rx_hold_served != rx_hold_requests)
        begin
            rx_hold_served <= rx_hold_requests;
            rx_hold_left <= LONG_HOLD;
        end
        else if (rx_hold_left > 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    // Result monitor: compares each result transaction with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        out_item_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (zone_reports_due.size() == 0)
                begin
                    bad_reports++;
                    if (bad_reports <= SHOWN_ERRORS)
                        $display("%0t: result with none expected: speed %0d zone %0d lag %0b",
                                 $time, out_data.speed_code, out_data.zone, out_data.lag_flag);
                end
                else
                begin
                    want = zone_reports_due.pop_front();
                    if (out_data.speed_code !== want.speed_code || out_data.zone !== want.zone
                        || out_data.lag_flag !== want.lag_flag)
                    begin
                        bad_reports++;
                        if (bad_reports <= SHOWN_ERRORS)
                            $display("%0t: mismatch speed %0d/%0d zone %0d/%0d lag %0b/%0b %s",
                                     $time, want.speed_code, out_data.speed_code, want.zone,
                                     out_data.zone, want.lag_flag, out_data.lag_flag,
                                     "(expected/actual)");
                    end
                end
            end
            out_ready <= (rx_hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Run limit.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** angle_zone_locator_speed_select_core: FAILED **");
        $finish;
    end

    // One register write transaction; the predictor copy follows on acceptance.
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ZERO_ANGLE_A:     regs_model.zero_angle_a = value[ANGLE_W-1:0];
            CFG_ZERO_ANGLE_B:     regs_model.zero_angle_b = value[ANGLE_W-1:0];
            CFG_ZERO_ANGLE_C:     regs_model.zero_angle_c = value[ANGLE_W-1:0];
            CFG_ZERO_TOLERANCE:   regs_model.zero_tolerance = value[ANGLE_W-1:0];
            CFG_ZONE_BOUNDS_LOW:  regs_model.zone_bounds_low = value[BOUNDS_LOW_W-1:0];
            CFG_ZONE_BOUNDS_HIGH: regs_model.zone_bounds_high = value[BOUNDS_HIGH_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_all(input logic [ANGLE_W-1:0] a, input logic [ANGLE_W-1:0] b,
                               input logic [ANGLE_W-1:0] c, input logic [ANGLE_W-1:0] tol,
                               input logic [BOUNDS_LOW_W-1:0] lo,
                               input logic [BOUNDS_HIGH_W-1:0] hi);
        write_reg(CFG_ZERO_ANGLE_A, CFG_DATA_W'(a));
        write_reg(CFG_ZERO_ANGLE_B, CFG_DATA_W'(b));
        write_reg(CFG_ZERO_ANGLE_C, CFG_DATA_W'(c));
        write_reg(CFG_ZERO_TOLERANCE, CFG_DATA_W'(tol));
        write_reg(CFG_ZONE_BOUNDS_LOW, CFG_DATA_W'(lo));
        write_reg(CFG_ZONE_BOUNDS_HIGH, CFG_DATA_W'(hi));
    endtask

    // Random setting; ordered bounds give a usable zone ladder, unordered ones odd cases.
    task automatic program_random(input logic ordered);
        logic [BOUNDS_LOW_W-1:0]  lo;
        logic [BOUNDS_HIGH_W-1:0] hi;
        int                       b;
        int                       k;
        int                       tol;
        lo = {8'($urandom), 32'($urandom)};
        hi = 30'($urandom);
        if (ordered)
        begin
            b = $urandom_range(0, 30);
            for (k = 1; k <= 7; k++)
            begin
                if (k <= 4)
                    lo[BOUND_W*(k-1) +: BOUND_W] = b[BOUND_W-1:0];
                else
                    hi[BOUND_W*(k-5) +: BOUND_W] = b[BOUND_W-1:0];
                b = b + $urandom_range(8, 70);
            end
        end
        tol = $urandom_range(1) ? $urandom_range(0, 60) : $urandom_range(0, 512);
        program_all(ANGLE_W'($urandom_range(0, 1023)), ANGLE_W'($urandom_range(0, 1023)),
                    ANGLE_W'($urandom_range(0, 1023)), tol[ANGLE_W-1:0], lo, hi);
    endtask

    task automatic push_sample(input int angle, input logic step, input logic hold);
        in_item_t s;
        s.angle = angle[ANGLE_W-1:0];
        s.step_level = step;
        s.hold_level = hold;
        sample_queue.push_back(s);
    endtask

    // Mostly slow runs around a zero with a toggling step pin, with some pure noise.
    task automatic queue_samples(input int n);
        in_item_t s;
        int       i;
        @(negedge clk);
        for (i = 0; i < n; i++)
        begin
            if (run_left == 0)
            begin
                run_noise = ($urandom_range(99) < 15);
                run_left = run_noise ? $urandom_range(1, 4) : $urandom_range(8, 32);
                case ($urandom_range(2))
                    0:       run_base = int'(regs_model.zero_angle_a);
                    1:       run_base = int'(regs_model.zero_angle_b);
                    default: run_base = int'(regs_model.zero_angle_c);
                endcase
                run_base = run_base + int'($urandom_range(0, 1040)) - 520;
                run_drift = $urandom_range(1) ? 1 : $urandom_range(2, 6);
            end
            run_left--;
            if (run_noise)
            begin
                s.angle = ANGLE_W'($urandom_range(0, 1023));
                s.step_level = 1'($urandom_range(1));
                s.hold_level = 1'($urandom_range(1));
            end
            else
            begin
                run_base = run_base + int'($urandom_range(0, 2 * run_drift)) - run_drift;
                if ($urandom_range(2) != 0)
                    step_now = ~step_now;
                s.angle = run_base[ANGLE_W-1:0];
                s.step_level = step_now;
                s.hold_level = ($urandom_range(99) >= 4);
            end
            sample_queue.push_back(s);
        end
    endtask

    // Waits until every offered sample has its result, then lets the pipeline settle.
    task automatic wait_drained();
        @(negedge clk);
        while (sample_queue.size() != 0 || in_valid || zone_reports_due.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 2) @(negedge clk);
    endtask

    // Sequencer: reset, directed samples, then random phases over settings and idling.
    initial
    begin : sequencer
        int p;
        int i;
        int half;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Extremes of the angle under the reset setting.
        @(negedge clk);
        push_sample(0, 1'b0, 1'b1);
        push_sample(1023, 1'b1, 1'b1);
        wait_drained();

        // Three spread zeros and a fine zone ladder.
        program_all(10'd100, 10'd400, 10'd700, 10'd20,
                    {10'd70, 10'd50, 10'd30, 10'd10}, {10'd130, 10'd110, 10'd90});
        @(negedge clk);
        // Far from the tracked zero with hold low, then inside zeros b and c.
        push_sample(512, 1'b0, 1'b0);
        push_sample(400, 1'b1, 1'b1);
        push_sample(700, 1'b0, 1'b1);
        // Equal distance to zeros a and b while far from c: the snap picks a.
        push_sample(250, 1'b1, 1'b1);
        // Steady zone three to confirm it, step edges within the lag tolerance.
        for (i = 0; i < 12; i++)
            push_sample(160 + (i % 2), i[0], 1'b1);
        // Drop to zone one, which turns the hysteresis on.
        for (i = 0; i < 5; i++)
            push_sample(125, 1'b0, 1'b1);
        wait_drained();

        for (p = 1; p <= PHASE_COUNT; p++)
        begin
            case (p % 4)
                0:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct = 62;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 62;
                end
                default:
                begin
                    tx_idle_pct = 26;
                    rx_stall_pct = 26;
                end
            endcase
            if (p == 4)
                program_all('0, '0, '0, '0, '0, '0);
            else if (p == 5)
                program_all('1, '1, '1, 10'd512, '1, '1);
            else
                program_random(p != 9);

            half = PHASE_SAMPLES / 2;
            queue_samples(half);
            // The receiver holds off while samples keep coming, so the block backs up.
            if (p == 4 || p == 8)
                rx_hold_requests++;
            // Sender pause until all results are back.
            wait_drained();
            queue_samples(PHASE_SAMPLES - half);
            wait_drained();
        end

        if (bad_reports == 0)
            $display("** angle_zone_locator_speed_select_core: PASSED **");
        else
            $display("** angle_zone_locator_speed_select_core: FAILED **");
        $finish;
    end

endmodule
